FILE: hw/rtl/wlm_pkg.sv
package wlm_pkg;

  // Pattern storage geometry.
  localparam int MAX_PATTERN = 32;
  localparam int PAT_WORDS   = 4;
  localparam int WORD_W      = 64;
  localparam int BYTE_W      = 8;
  localparam int PAT_BYTES   = PAT_WORDS * WORD_W / BYTE_W;
  localparam int PAT_BITS    = PAT_BYTES * BYTE_W;

  // Byte positions, segment lengths and the saturating counters.
  localparam int POS_W  = $clog2(MAX_PATTERN);
  localparam int LEN_W  = $clog2(MAX_PATTERN + 2);
  localparam int PLEN_W = 6;

  // Configuration port.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_THIRD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN    = 3'd4;

  localparam logic [BYTE_W-1:0] PERCENT = 8'h25;

  // One literal segment: position of its final byte and its length.
  typedef struct packed {
    logic [POS_W-1:0] last_pos;
    logic [LEN_W-1:0] len;
  } seg_entry_t;

  // Parsed pattern summary handed to the scanner.
  typedef struct packed {
    logic [LEN_W-1:0] seg_count;
    logic             lead_pct;
    logic             trail_pct;
    logic             busy;
  } pat_info_t;

  function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/wlm_parse.sv
module wlm_parse
  import wlm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic [POS_W-1:0]     rd_sel,
  output seg_entry_t           rd_entry,
  output pat_info_t            info,
  output logic [PAT_BITS-1:0]  pat_lc
);

  logic [WORD_W-1:0] pat_word [PAT_WORDS];
  logic [PLEN_W-1:0] pat_len;
  logic              busy;
  logic [LEN_W-1:0]  scan_pos;
  logic [LEN_W-1:0]  run;
  logic [LEN_W-1:0]  seg_count;
  seg_entry_t        seg_tab [MAX_PATTERN];

  logic              cfg_hit;
  logic [LEN_W-1:0]  used_len;
  logic [BYTE_W-1:0] cur_byte;
  logic              end_run;
  logic [POS_W-1:0]  tail_pos;
  seg_entry_t        new_entry;

  always_comb begin
    unique case (cfg_index) inside
      REG_PAT_LOW, REG_PAT_SECOND, REG_PAT_THIRD, REG_PAT_HIGH, REG_PAT_LEN: begin
        cfg_hit = cfg_valid;
      end
      default: begin
        cfg_hit = 1'b0;
      end
    endcase
  end

  // Lower-cased pattern, byte k at bits 8k+7..8k.
  for (genvar w = 0; w < PAT_WORDS; w++) begin : g_word
    for (genvar b = 0; b < WORD_W / BYTE_W; b++) begin : g_byte
      assign pat_lc[(w * (WORD_W / BYTE_W) + b) * BYTE_W +: BYTE_W] =
        to_lower(pat_word[w][b * BYTE_W +: BYTE_W]);
    end
  end

  assign used_len = (LEN_W'(pat_len) > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                             : LEN_W'(pat_len);
  assign cur_byte = pat_lc[scan_pos[POS_W-1:0] * BYTE_W +: BYTE_W];
  assign end_run  = (scan_pos == used_len) || (cur_byte == PERCENT);
  assign tail_pos = POS_W'(used_len - LEN_W'(1));

  assign new_entry.last_pos = POS_W'(scan_pos - LEN_W'(1));
  assign new_entry.len      = run;

  // The sweep walks the pattern one byte a cycle and records each literal run.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAT_WORDS; i++) begin
        pat_word[i] <= '0;
      end
      pat_len   <= '0;
      busy      <= 1'b1;
      scan_pos  <= '0;
      run       <= '0;
      seg_count <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        REG_PAT_LOW:    pat_word[0] <= cfg_data;
        REG_PAT_SECOND: pat_word[1] <= cfg_data;
        REG_PAT_THIRD:  pat_word[2] <= cfg_data;
        REG_PAT_HIGH:   pat_word[3] <= cfg_data;
        REG_PAT_LEN:    pat_len     <= cfg_data[PLEN_W-1:0];
        default: begin
        end
      endcase
      busy      <= 1'b1;
      scan_pos  <= '0;
      run       <= '0;
      seg_count <= '0;
    end else if (busy) begin
      if (end_run) begin
        run <= '0;
        if (run != '0) begin
          seg_count <= seg_count + LEN_W'(1);
        end
      end else begin
        run <= run + LEN_W'(1);
      end
      if (scan_pos == used_len) begin
        busy <= 1'b0;
      end else begin
        scan_pos <= scan_pos + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst && !cfg_hit && busy && end_run && run != '0) begin
      seg_tab[seg_count[POS_W-1:0]] <= new_entry;
    end
  end

  assign rd_entry       = seg_tab[rd_sel];
  assign info.seg_count = seg_count;
  assign info.lead_pct  = (used_len != '0) && (pat_lc[BYTE_W-1:0] == PERCENT);
  assign info.trail_pct = (used_len != '0) &&
                          (pat_lc[tail_pos * BYTE_W +: BYTE_W] == PERCENT);
  assign info.busy      = busy;

endmodule

FILE: hw/rtl/wlm_scan.sv
module wlm_scan
  import wlm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [BYTE_W-1:0]   text_char,
  input  logic                last,
  input  logic                no_char,
  input  pat_info_t           info,
  input  seg_entry_t          entry,
  input  logic [PAT_BITS-1:0] pat_lc,
  output logic [POS_W-1:0]    rd_sel,
  output logic                push,
  output logic                result
);

  logic [PAT_BITS-1:0] window;
  logic [LEN_W-1:0]    segment_number;
  logic [LEN_W-1:0]    bytes_since_anchor;
  logic [LEN_W-1:0]    text_length_seen;
  logic                wildcard_open;
  logic                has_failed;

  logic [PAT_BITS-1:0] eff_win;
  logic [LEN_W-1:0]    bsa_eff;
  logic [LEN_W-1:0]    tls_eff;
  logic [PAT_BITS-1:0] pat_rev;
  logic [PAT_BITS-1:0] aligned;
  logic [POS_W-1:0]    shift_amt;
  logic [PAT_BYTES-1:0] lane_ok;
  logic                win_match;
  logic                past_end;
  logic                is_suffix;
  logic                active;
  logic                advance;
  logic                fail_new;
  logic [LEN_W-1:0]    seg_inc;

  assign rd_sel = segment_number[POS_W-1:0];

  // Window after this request's byte, and the counters that go with it.
  assign eff_win = no_char ? window : {window[PAT_BITS-BYTE_W-1:0], to_lower(text_char)};
  assign bsa_eff = (no_char || bytes_since_anchor == LEN_W'(MAX_PATTERN)) ?
                   bytes_since_anchor : bytes_since_anchor + LEN_W'(1);
  assign tls_eff = (no_char || text_length_seen == LEN_W'(MAX_PATTERN + 1)) ?
                   text_length_seen : text_length_seen + LEN_W'(1);

  // Line the segment up with the window: byte j of the window meets
  // pattern byte (last_pos - j).
  for (genvar i = 0; i < PAT_BYTES; i++) begin : g_rev
    assign pat_rev[i * BYTE_W +: BYTE_W] = pat_lc[(PAT_BYTES - 1 - i) * BYTE_W +: BYTE_W];
  end
  assign shift_amt = POS_W'(PAT_BYTES - 1) - entry.last_pos;
  assign aligned   = pat_rev >> {shift_amt, 3'b000};

  always_comb begin
    for (int j = 0; j < PAT_BYTES; j++) begin
      lane_ok[j] = (aligned[j * BYTE_W +: BYTE_W] == eff_win[j * BYTE_W +: BYTE_W]) ||
                   (LEN_W'(j) >= entry.len);
    end
  end
  assign win_match = (entry.len != '0) && (&lane_ok);

  assign past_end  = segment_number >= info.seg_count;
  assign is_suffix = (segment_number == info.seg_count - LEN_W'(1)) && !info.trail_pct;
  assign active    = !no_char && !has_failed && !past_end && !is_suffix;
  assign advance   = active && win_match &&
                     (wildcard_open ? (bsa_eff >= entry.len) : (bsa_eff == entry.len));
  assign fail_new  = active && !wildcard_open && (bsa_eff == entry.len) && !win_match;
  assign seg_inc   = segment_number + LEN_W'(1);

  // Verdict on the string as it stands after this request.
  always_comb begin
    if (info.seg_count == '0) begin
      result = 1'b1;
    end else if (has_failed || fail_new) begin
      result = 1'b0;
    end else if (advance) begin
      result = seg_inc >= info.seg_count;
    end else if (past_end) begin
      result = 1'b1;
    end else if (!is_suffix) begin
      result = 1'b0;
    end else if (wildcard_open) begin
      result = (bsa_eff >= entry.len) && win_match;
    end else begin
      result = (tls_eff == entry.len) && win_match;
    end
  end

  assign push = accept && last;

  always_ff @(posedge clk) begin
    if (rst || info.busy || push) begin
      window             <= '0;
      segment_number     <= '0;
      bytes_since_anchor <= '0;
      text_length_seen   <= '0;
      wildcard_open      <= info.lead_pct;
      has_failed         <= 1'b0;
    end else if (accept) begin
      window             <= eff_win;
      text_length_seen   <= tls_eff;
      bytes_since_anchor <= advance ? '0 : bsa_eff;
      segment_number     <= advance ? seg_inc : segment_number;
      wildcard_open      <= wildcard_open | advance;
      has_failed         <= has_failed | fail_new;
    end
  end

endmodule

FILE: hw/rtl/wlm_outbuf.sv
module wlm_outbuf
  import wlm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic din,
  input  logic out_ready,
  output logic out_valid,
  output logic dout,
  output logic space
);

  logic [1:0] fill;
  logic       head;
  logic       tail;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = fill != 2'd0;
  assign dout      = head;
  assign space     = fill != 2'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else if (push && !pop) begin
      fill <= fill + 2'd1;
    end else if (pop && !push) begin
      fill <= fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (fill == 2'd1) begin
        head <= din;
      end else begin
        head <= tail;
        tail <= din;
      end
    end else if (push) begin
      if (fill == 2'd0) begin
        head <= din;
      end else begin
        tail <= din;
      end
    end else if (pop) begin
      head <= tail;
    end
  end

endmodule

FILE: hw/rtl/wildcard_like_matcher_top.sv
// Case-insensitive '%' wildcard matcher: one text byte per request, one verdict per string.
// Throughput: one request every cycle; in_ready drops while two verdicts wait unread.
// Latency: a verdict shows on matched the cycle after its last byte, once earlier ones left.
// After reset, and after every write to a pattern or length register, the pattern sweep
// holds in_ready low while it records the literal segments.
// Reset is synchronous and clears the pattern to empty, which matches every string.
module wildcard_like_matcher_top
  import wlm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    text_char,
  input  logic                 last,
  input  logic                 no_char,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 matched
);

  pat_info_t           info;
  seg_entry_t          entry;
  logic [PAT_BITS-1:0] pat_lc;
  logic [POS_W-1:0]    rd_sel;
  logic                accept;
  logic                push;
  logic                result;
  logic                space;

  // Configuration writes are always taken; any register write restarts the string in progress.
  assign cfg_ready = 1'b1;

  // A request is taken while the segment table is settled and the result buffer
  // has a free slot. One verdict may wait on the output without stalling the
  // byte stream; a second one fills the buffer and holds in_ready low until
  // the oldest leaves.
  assign in_ready = !info.busy && space;
  assign accept   = in_valid && in_ready;

  // Holds the pattern registers and walks them into a table of literal segments.
  wlm_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_sel    (rd_sel),
    .rd_entry  (entry),
    .info      (info),
    .pat_lc    (pat_lc)
  );

  // Shifts each byte into the window, tests the sought segment and judges the
  // string when its last request arrives.
  wlm_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .text_char (text_char),
    .last      (last),
    .no_char   (no_char),
    .info      (info),
    .entry     (entry),
    .pat_lc    (pat_lc),
    .rd_sel    (rd_sel),
    .push      (push),
    .result    (result)
  );

  // Two-deep result buffer between the scanner and the output channel.
  wlm_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .dout      (matched),
    .space     (space)
  );

endmodule

FILE: dv/tb_wildcard_like_matcher_top.sv
`timescale 1ns / 1ps

module tb_wildcard_like_matcher_top;
  import wlm_pkg::*;

  typedef logic [BYTE_W-1:0] octet_t;

  // One text request as it goes over the input channel.
  typedef struct packed {
    octet_t ch;
    logic   fin;
    logic   skip;
  } text_req_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  octet_t               text_char = '0;
  logic                 last = 1'b0;
  logic                 no_char = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 matched;

  wildcard_like_matcher_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .text_char (text_char),
    .last      (last),
    .no_char   (no_char),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .matched   (matched)
  );

  always #2 clk = ~clk;

  // Requests waiting for the driver, and match verdicts waiting for the monitor.
  text_req_t bytes_to_send [$];
  bit        verdicts_due [$];
  text_req_t on_wire;

  int  requests_queued = 0;
  int  requests_taken = 0;
  int  counted_items = 0;
  int  error_count = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  bit  calm = 1'b0;

  // Stimulus scratch: the pattern image behind the four word registers, the
  // length last written, and a text string under construction.
  octet_t pat_img [MAX_PATTERN];
  int     cur_len = 0;
  octet_t draft [$];

  // ---------------------------------------------------------------------------
  // Matcher prediction. The pattern is split into literal segments at every
  // percent byte; text bytes go through a window, newest first, and the sought
  // segment is compared against the newest bytes of that window.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] pat_word [PAT_WORDS];
  logic [PLEN_W-1:0] pat_len_cfg;
  octet_t            window [MAX_PATTERN];
  int                seg_first [MAX_PATTERN];
  int                seg_size [MAX_PATTERN];
  int                seg_total;
  int                seg_at;
  int                since_anchor;
  int                seen_len;
  bit                lead_pct;
  bit                trail_pct;
  bit                floating;
  bit                failed;

  function automatic octet_t fold_case(input octet_t c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic octet_t pattern_char(input int k);
    return fold_case(pat_word[(k / 8) % PAT_WORDS][(k % 8) * BYTE_W +: BYTE_W]);
  endfunction

  function automatic void split_segments();
    int  n;
    int  run;
    bit  boundary;
    n = pat_len_cfg;
    if (n > MAX_PATTERN) n = MAX_PATTERN;
    seg_total = 0;
    run = 0;
    lead_pct = n > 0 && pattern_char(0) == PERCENT;
    trail_pct = n > 0 && pattern_char(n - 1) == PERCENT;
    for (int k = 0; k <= n; k++) begin
      boundary = (k == n) ? 1'b1 : (pattern_char(k) == PERCENT);
      if (boundary) begin
        if (run > 0) begin
          seg_first[seg_total] = k - run;
          seg_size[seg_total] = run;
          seg_total++;
        end
        run = 0;
      end else begin
        run++;
      end
    end
  endfunction

  function automatic bit segment_in_window(input int s);
    int len;
    len = seg_size[s];
    for (int i = 0; i < len; i++) begin
      if (window[len - 1 - i] != pattern_char(seg_first[s] + i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void restart_string_state();
    split_segments();
    foreach (window[i]) window[i] = '0;
    seg_at = 0;
    since_anchor = 0;
    seen_len = 0;
    floating = lead_pct;
    failed = 1'b0;
  endfunction

  function automatic void advance_segment();
    seg_at++;
    since_anchor = 0;
    floating = 1'b1;
  endfunction

  function automatic void feed_byte(input octet_t c);
    int len;
    for (int i = MAX_PATTERN - 1; i > 0; i--) window[i] = window[i - 1];
    window[0] = c;
    if (seen_len < MAX_PATTERN + 1) seen_len++;
    if (since_anchor < MAX_PATTERN) since_anchor++;
    if (failed || seg_at >= seg_total) return;
    // The closing segment without a trailing percent is only judged at the end.
    if (seg_at == seg_total - 1 && !trail_pct) return;
    len = seg_size[seg_at];
    if (!floating) begin
      if (since_anchor == len) begin
        if (segment_in_window(seg_at)) advance_segment();
        else failed = 1'b1;
      end
    end else if (since_anchor >= len && segment_in_window(seg_at)) begin
      advance_segment();
    end
  endfunction

  function automatic bit string_verdict();
    int len;
    if (seg_total == 0) return 1'b1;
    if (failed) return 1'b0;
    if (seg_at >= seg_total) return 1'b1;
    if (seg_at != seg_total - 1 || trail_pct) return 1'b0;
    len = seg_size[seg_at];
    if (floating) return since_anchor >= len && segment_in_window(seg_at);
    return seen_len == len && segment_in_window(seg_at);
  endfunction

  function automatic void write_pattern_reg(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [WORD_W-1:0] data);
    case (idx)
      REG_PAT_LOW:    pat_word[0] = data;
      REG_PAT_SECOND: pat_word[1] = data;
      REG_PAT_THIRD:  pat_word[2] = data;
      REG_PAT_HIGH:   pat_word[3] = data;
      REG_PAT_LEN:    pat_len_cfg = data[PLEN_W-1:0];
      default:        return;
    endcase
    restart_string_state();
  endfunction

  function automatic void track_request(input text_req_t r);
    if (!r.skip) feed_byte(fold_case(r.ch));
    if (r.fin) begin
      verdicts_due.insert(verdicts_due.size(), string_verdict());
      restart_string_state();
    end
  endfunction

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%0t: %s", $time, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. Each accepted request updates the prediction at the same edge, so
  // the expected verdict is in place long before the block can answer. Gaps
  // start only after an accepted request, so valid never drops with a request
  // still pending.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        track_request(on_wire);
        requests_taken++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (bytes_to_send.size() > 0) begin
          on_wire = bytes_to_send.pop_front();
          text_char <= on_wire.ch;
          last <= on_wire.fin;
          no_char <= on_wire.skip;
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 11) == 0) in_gap = $urandom_range(1, 18);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Every verdict taken is checked against the oldest prediction; the
  // ready side stalls in bursts of its own.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          note_error($sformatf("verdict with none expected: matched=%0b", matched));
        end else begin
          if (matched !== verdicts_due[0]) begin
            note_error($sformatf("matched mismatch: expected %0b, got %0b",
                                 verdicts_due[0], matched));
          end
          void'(verdicts_due.pop_front());
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 18);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // A request with skip and no fin is dropped by the block, so it does not
  // count toward the size of the run.
  function automatic void push_item(input octet_t ch, input bit fin, input bit skip);
    text_req_t r;
    r.ch = ch;
    r.fin = fin;
    r.skip = skip;
    bytes_to_send.insert(bytes_to_send.size(), r);
    requests_queued++;
    if (!skip || fin) counted_items++;
  endfunction

  function automatic octet_t pick_char();
    string pool;
    pool = "abcABC%";
    if ($urandom_range(0, 7) == 0) return octet_t'($urandom_range(0, 255));
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  function automatic octet_t flip_case(input octet_t c);
    bit letter;
    letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    return (letter && $urandom_range(0, 1)) ? c ^ 8'h20 : c;
  endfunction

  function automatic void image_from(input string p, input octet_t fill);
    for (int k = 0; k < MAX_PATTERN; k++) pat_img[k] = (k < p.len()) ? p[k] : fill;
  endfunction

  function automatic void draft_from(input string s);
    draft.delete();
    for (int i = 0; i < s.len(); i++) draft.insert(draft.size(), s[i]);
  endfunction

  // Sends the drafted string. A noisy string gets stray empty requests mixed in
  // and now and then ends on an empty request that carries last. An open string
  // is never closed, so a later pattern or length write has to restart it.
  function automatic void queue_draft(input bit close, input bit noisy);
    bit tail_blank;
    tail_blank = noisy && $urandom_range(0, 9) == 0;
    for (int i = 0; i < draft.size(); i++) begin
      if (noisy && $urandom_range(0, 15) == 0) begin
        push_item(octet_t'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
      push_item(draft[i], close && !tail_blank && i == draft.size() - 1, 1'b0);
    end
    if (close && (tail_blank || draft.size() == 0)) begin
      push_item(octet_t'($urandom_range(0, 255)), 1'b1, 1'b1);
    end
  endfunction

  // Random pattern image: mostly the letters a to c in either case and percents,
  // sometimes pure noise or all ones so that every bit of the word registers toggles.
  task automatic make_pattern(output int len_cfg);
    string pool;
    int    kind;
    pool = "abcABC";
    kind = $urandom_range(0, 11);
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (kind == 0) pat_img[k] = octet_t'($urandom_range(0, 255));
      else if (kind == 1) pat_img[k] = 8'hFF;
      else if ($urandom_range(0, 9) < 3) pat_img[k] = PERCENT;
      else if ($urandom_range(0, 19) == 0) pat_img[k] = octet_t'($urandom_range(0, 255));
      else pat_img[k] = pool[$urandom_range(0, pool.len() - 1)];
    end
    case ($urandom_range(0, 11))
      0:       len_cfg = 0;
      1:       len_cfg = MAX_PATTERN;
      2:       len_cfg = $urandom_range(MAX_PATTERN + 1, (1 << PLEN_W) - 1);
      3, 4:    len_cfg = $urandom_range(13, MAX_PATTERN - 1);
      default: len_cfg = $urandom_range(1, 12);
    endcase
  endtask

  // Builds text that follows the pattern: literal bytes with random case and
  // random filler for each percent, then maybe one edit to break it. Some
  // strings are plain noise instead.
  task automatic build_text(input int used_len);
    int extra;
    draft.delete();
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(0, 40)) draft.insert(draft.size(), octet_t'($urandom_range(0, 255)));
    end else begin
      for (int k = 0; k < used_len; k++) begin
        if (pat_img[k] == PERCENT) begin
          extra = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
          repeat (extra) draft.insert(draft.size(), pick_char());
        end else begin
          draft.insert(draft.size(), flip_case(pat_img[k]));
        end
      end
      case ($urandom_range(0, 5))
        0: if (draft.size() > 0) draft[$urandom_range(0, draft.size() - 1)] = pick_char();
        1: if (draft.size() > 0) draft.delete($urandom_range(0, draft.size() - 1));
        2: draft.insert(draft.size(), pick_char());
        3: draft.push_front(pick_char());
        default: ;
      endcase
    end
  endtask

  // Register writes go back to back with valid held high; the caller starts at
  // a clock edge and the write counts at the edge where ready is seen.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    write_pattern_reg(idx, data);
  endtask

  task automatic program_pattern(input int len_cfg, input bit len_only, input bit stray);
    logic [WORD_W-1:0]    word;
    logic [CFG_IDX_W-1:0] idx;
    if (stray) begin
      write_reg(CFG_IDX_W'($urandom_range(REG_PAT_LEN + 1, (1 << CFG_IDX_W) - 1)),
                {$urandom, $urandom});
    end
    if (!len_only) begin
      for (int w = 0; w < PAT_WORDS; w++) begin
        for (int b = 0; b < 8; b++) word[b * BYTE_W +: BYTE_W] = pat_img[w * 8 + b];
        case (w)
          0:       idx = REG_PAT_LOW;
          1:       idx = REG_PAT_SECOND;
          2:       idx = REG_PAT_THIRD;
          default: idx = REG_PAT_HIGH;
        endcase
        write_reg(idx, word);
      end
    end
    write_reg(REG_PAT_LEN, WORD_W'(len_cfg));
    cur_len = len_cfg;
    cfg_valid <= 1'b0;
  endtask

  // Waits until every queued request is taken and every verdict has come
  // back, then lets a few cycles pass: a request without last leaves nothing
  // to wait for, yet the block may still be working on it.
  task automatic settle();
    do @(posedge clk);
    while (requests_taken != requests_queued || verdicts_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int  new_len;
    int  used_len;
    bit  len_only;

    foreach (pat_word[i]) pat_word[i] = '0;
    pat_len_cfg = '0;
    restart_string_state();
    foreach (pat_img[i]) pat_img[i] = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Out of reset the pattern is empty: the empty string and any single
    // byte match.
    push_item(8'h5A, 1'b1, 1'b1);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hFF, 1'b1, 1'b0);
    settle();

    // No percent at all, with an upper-case pattern byte: the text must equal
    // the pattern whatever the case. A stray empty request in the middle of
    // the string changes nothing.
    image_from("aBc", 8'h00);
    program_pattern(3, 1'b0, 1'b0);
    push_item("A", 1'b0, 1'b0);
    push_item(8'h3C, 1'b0, 1'b1);
    push_item("B", 1'b0, 1'b0);
    push_item("C", 1'b1, 1'b0);
    draft_from("abcd");
    queue_draft(1'b1, 1'b0);
    settle();

    // Percent only: everything matches, the empty string too.
    image_from("%%", PERCENT);
    program_pattern(2, 1'b0, 1'b0);
    draft_from("q");
    queue_draft(1'b1, 1'b0);
    push_item(8'h00, 1'b1, 1'b1);
    settle();

    // Length beyond the storage: all 32 bytes are used, here a single
    // floating 'z' among percents.
    image_from("%%%%%Z", PERCENT);
    program_pattern((1 << PLEN_W) - 1, 1'b0, 1'b0);
    draft_from("aZ");
    queue_draft(1'b1, 1'b0);
    settle();

    // Anchored head, floating middle and a tail that must end the text.
    image_from("a%b%c", 8'h00);
    program_pattern(5, 1'b0, 1'b0);
    draft_from("AxBc");
    queue_draft(1'b1, 1'b0);
    draft_from("abcb");
    queue_draft(1'b1, 1'b0);
    settle();

    // Random phases: a new pattern (or only a new length, or a write to an
    // unused index first), then a batch of strings shaped after it. Now and
    // then a string is left open for a pattern or length write to cut off.
    // The last stretch runs with both sides at full rate.
    while (counted_items < 1200) begin
      len_only = $urandom_range(0, 5) == 0;
      if (len_only) new_len = $urandom_range(0, (1 << PLEN_W) - 1);
      else make_pattern(new_len);
      program_pattern(new_len, len_only, $urandom_range(0, 7) == 0);
      used_len = (cur_len > MAX_PATTERN) ? MAX_PATTERN : cur_len;
      repeat ($urandom_range(3, 12)) begin
        build_text(used_len);
        queue_draft(1'b1, 1'b1);
      end
      if ($urandom_range(0, 5) == 0) begin
        build_text(used_len);
        queue_draft(1'b0, 1'b1);
      end
      if (counted_items >= 1050) calm = 1'b1;
      settle();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/wlm_pkg.sv
hw/rtl/wlm_parse.sv
hw/rtl/wlm_scan.sv
hw/rtl/wlm_outbuf.sv
hw/rtl/wildcard_like_matcher_top.sv
dv/tb_wildcard_like_matcher_top.sv
